// ===== rtl/y2p_pkg.sv =====
// Shared types and constants for the YUY2 to planar YUV address generator.
// Used by every module under rtl; depends on nothing.
package y2p_pkg;

    localparam int BYTE_W        = 8;
    localparam int DIM_W         = 11;
    localparam int LUMA_ADDR_W   = 20;
    localparam int CHROMA_ADDR_W = 19;
    // chroma products keep three extra low bits for the /2, /4 and /8 terms
    localparam int CHROMA_PROD_W = CHROMA_ADDR_W + 3;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_CHROMA_MODE = 3'd0;
    localparam logic [2:0] REG_IN_WIDTH    = 3'd1;
    localparam logic [2:0] REG_IN_HEIGHT   = 3'd2;
    localparam logic [2:0] REG_OUT_WIDTH   = 3'd3;
    localparam logic [2:0] REG_OUT_HEIGHT  = 3'd4;

    localparam logic [DIM_W-1:0] RST_IN_WIDTH   = 11'd352;
    localparam logic [DIM_W-1:0] RST_IN_HEIGHT  = 11'd288;
    localparam logic [DIM_W-1:0] RST_OUT_WIDTH  = 11'd352;
    localparam logic [DIM_W-1:0] RST_OUT_HEIGHT = 11'd288;

    typedef struct packed {
        logic             chroma_mode;
        logic [DIM_W-1:0] in_width;
        logic [DIM_W-1:0] in_height;
        logic [DIM_W-1:0] out_width;
        logic [DIM_W-1:0] out_height;
    } cfg_t;

    typedef struct packed {
        logic chroma_on;
        logic frame_end;
    } pair_flags_t;

endpackage

// ===== rtl/y2p_cfg.sv =====
// APB-style configuration registers: chroma mode and frame sizes.
// Depends on y2p_pkg.
module y2p_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [y2p_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [y2p_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [y2p_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output y2p_pkg::cfg_t                     cfg
);

    y2p_pkg::cfg_t cfg_reg;
    y2p_pkg::cfg_t cfg_next;
    logic [2:0]    reg_index;
    logic          wr_en;

    assign reg_index = paddr[y2p_pkg::APB_ADDR_W-1:2];
    assign wr_en     = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_index)
                y2p_pkg::REG_CHROMA_MODE: cfg_next.chroma_mode = pwdata[0];
                y2p_pkg::REG_IN_WIDTH:    cfg_next.in_width    = pwdata[y2p_pkg::DIM_W-1:0];
                y2p_pkg::REG_IN_HEIGHT:   cfg_next.in_height   = pwdata[y2p_pkg::DIM_W-1:0];
                y2p_pkg::REG_OUT_WIDTH:   cfg_next.out_width   = pwdata[y2p_pkg::DIM_W-1:0];
                y2p_pkg::REG_OUT_HEIGHT:  cfg_next.out_height  = pwdata[y2p_pkg::DIM_W-1:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.chroma_mode <= 1'b0;
            cfg_reg.in_width    <= y2p_pkg::RST_IN_WIDTH;
            cfg_reg.in_height   <= y2p_pkg::RST_IN_HEIGHT;
            cfg_reg.out_width   <= y2p_pkg::RST_OUT_WIDTH;
            cfg_reg.out_height  <= y2p_pkg::RST_OUT_HEIGHT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_index)
            y2p_pkg::REG_CHROMA_MODE:
                prdata = y2p_pkg::APB_DATA_W'(cfg_reg.chroma_mode);
            y2p_pkg::REG_IN_WIDTH:   prdata = y2p_pkg::APB_DATA_W'(cfg_reg.in_width);
            y2p_pkg::REG_IN_HEIGHT:  prdata = y2p_pkg::APB_DATA_W'(cfg_reg.in_height);
            y2p_pkg::REG_OUT_WIDTH:  prdata = y2p_pkg::APB_DATA_W'(cfg_reg.out_width);
            y2p_pkg::REG_OUT_HEIGHT: prdata = y2p_pkg::APB_DATA_W'(cfg_reg.out_height);
            default:                 prdata = '0;
        endcase
    end

endmodule

// ===== rtl/y2p_scan.sv =====
// Raster scan counters and input register stage.
// Tags each accepted pixel pair with its row, column and chroma/frame flags.
// Depends on y2p_pkg.
module y2p_scan
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  y2p_pkg::cfg_t               cfg,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [y2p_pkg::BYTE_W-1:0]  luma_first,
    input  logic [y2p_pkg::BYTE_W-1:0]  chroma_blue,
    input  logic [y2p_pkg::BYTE_W-1:0]  luma_second,
    input  logic [y2p_pkg::BYTE_W-1:0]  chroma_red,
    input  logic                        a_ready,
    output logic                        a_valid,
    output logic [$clog2(MAX_HEIGHT)-1:0] a_row,
    output logic [$clog2(MAX_WIDTH)-1:0]  a_col,
    output logic [y2p_pkg::BYTE_W-1:0]  a_y0,
    output logic [y2p_pkg::BYTE_W-1:0]  a_u,
    output logic [y2p_pkg::BYTE_W-1:0]  a_y1,
    output logic [y2p_pkg::BYTE_W-1:0]  a_v,
    output y2p_pkg::pair_flags_t        a_flags
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int BIG_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CMP_W = ((BIG_W > y2p_pkg::DIM_W) ? BIG_W : y2p_pkg::DIM_W) + 2;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic             a_valid_reg, a_valid_next;
    logic [ROW_W-1:0] a_row_reg;
    logic [COL_W-1:0] a_col_reg;
    logic [y2p_pkg::BYTE_W-1:0] a_y0_reg, a_u_reg, a_y1_reg, a_v_reg;
    y2p_pkg::pair_flags_t a_flags_reg;
    y2p_pkg::pair_flags_t flags;

    logic [CMP_W-1:0] w_lim;
    logic [CMP_W-1:0] h_lim;
    logic             row_end;
    logic             accept;

    assign in_ready = !a_valid_reg || a_ready;
    assign accept   = in_valid && in_ready;

    // clamp the counting sizes to the counter range
    assign w_lim = (CMP_W'(cfg.in_width) > CMP_W'(MAX_WIDTH)) ?
                   CMP_W'(MAX_WIDTH) : CMP_W'(cfg.in_width);
    assign h_lim = (CMP_W'(cfg.in_height) > CMP_W'(MAX_HEIGHT)) ?
                   CMP_W'(MAX_HEIGHT) : CMP_W'(cfg.in_height);

    assign row_end         = (CMP_W'(col_reg) + CMP_W'(2)) >= w_lim;
    assign flags.frame_end = row_end && ((CMP_W'(row_reg) + CMP_W'(1)) >= h_lim);
    // 4:2:0 writes chroma on even rows only
    assign flags.chroma_on = !cfg.chroma_mode || !row_reg[0];

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (accept)
        begin
            if (row_end)
            begin
                col_next = '0;
                row_next = flags.frame_end ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(2);
            end
        end
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (accept)
            a_valid_next = 1'b1;
        else if (a_ready)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            a_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_row_reg   <= row_reg;
            a_col_reg   <= col_reg;
            a_y0_reg    <= luma_first;
            a_u_reg     <= chroma_blue;
            a_y1_reg    <= luma_second;
            a_v_reg     <= chroma_red;
            a_flags_reg <= flags;
        end
    end

    assign a_valid = a_valid_reg;
    assign a_row   = a_row_reg;
    assign a_col   = a_col_reg;
    assign a_y0    = a_y0_reg;
    assign a_u     = a_u_reg;
    assign a_y1    = a_y1_reg;
    assign a_v     = a_v_reg;
    assign a_flags = a_flags_reg;

endmodule

// ===== rtl/y2p_addr.sv =====
// Plane address logic: one combinational pass from the input register into
// the output register. Depends on y2p_pkg.
module y2p_addr
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  y2p_pkg::cfg_t                      cfg,
    input  logic                               a_valid,
    output logic                               a_ready,
    input  logic [$clog2(MAX_HEIGHT)-1:0]      a_row,
    input  logic [$clog2(MAX_WIDTH)-1:0]       a_col,
    input  logic [y2p_pkg::BYTE_W-1:0]         a_y0,
    input  logic [y2p_pkg::BYTE_W-1:0]         a_u,
    input  logic [y2p_pkg::BYTE_W-1:0]         a_y1,
    input  logic [y2p_pkg::BYTE_W-1:0]         a_v,
    input  y2p_pkg::pair_flags_t               a_flags,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [y2p_pkg::LUMA_ADDR_W-1:0]    luma_address,
    output logic [y2p_pkg::BYTE_W-1:0]         luma_out_first,
    output logic [y2p_pkg::BYTE_W-1:0]         luma_out_second,
    output logic                               chroma_write,
    output logic [y2p_pkg::CHROMA_ADDR_W-1:0]  chroma_address,
    output logic [y2p_pkg::BYTE_W-1:0]         blue_out,
    output logic [y2p_pkg::BYTE_W-1:0]         red_out,
    output logic                               frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int BIG_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int SUM_W = ((BIG_W > y2p_pkg::DIM_W) ? BIG_W : y2p_pkg::DIM_W) + 2;
    localparam int LA_W  = y2p_pkg::LUMA_ADDR_W;
    localparam int CA_W  = y2p_pkg::CHROMA_ADDR_W;
    localparam int CP_W  = y2p_pkg::CHROMA_PROD_W;

    logic [y2p_pkg::DIM_W-1:0] dh, dw;
    logic [SUM_W-1:0]          luma_row;
    logic [LA_W-1:0]           luma_prod;
    logic [CP_W-1:0]           chroma_prod;
    logic [CP_W-1:0]           offset_prod;

    logic                      out_valid_reg, out_valid_next;
    logic [LA_W-1:0]           luma_addr_next;
    logic [CA_W-1:0]           chroma_addr_next;
    logic [LA_W-1:0]           luma_addr_reg;
    logic [CA_W-1:0]           chroma_addr_reg;
    logic [y2p_pkg::BYTE_W-1:0] y0_reg, y1_reg, u_reg, v_reg;
    y2p_pkg::pair_flags_t      flags_reg;

    logic                      load_c;

    assign load_c  = !out_valid_reg || out_ready;
    assign a_ready = load_c;

    // centering margins, zero when the output is smaller than the input
    assign dh = (cfg.out_height > cfg.in_height) ? cfg.out_height - cfg.in_height : '0;
    assign dw = (cfg.out_width  > cfg.in_width)  ? cfg.out_width  - cfg.in_width  : '0;

    assign luma_row    = SUM_W'(a_row) + SUM_W'(dh >> 1);
    assign luma_prod   = LA_W'(LA_W'(luma_row) * LA_W'(cfg.out_width));
    assign chroma_prod = CP_W'(CP_W'(a_row) * CP_W'(cfg.out_width));
    assign offset_prod = CP_W'(CP_W'(dh) * CP_W'(cfg.out_width));

    assign luma_addr_next = luma_prod + LA_W'(dw >> 1) + LA_W'(a_col);

    always_comb
    begin
        if (!a_flags.chroma_on)
            chroma_addr_next = '0;
        else if (!cfg.chroma_mode)
            chroma_addr_next = CA_W'(chroma_prod[CP_W-1:1]) + CA_W'(a_col >> 1);
        else
            chroma_addr_next = CA_W'(chroma_prod[CP_W-1:2])
                             + CA_W'(a_col >> 1)
                             + CA_W'(offset_prod[CP_W-1:3])
                             + CA_W'(dw >> 2);
    end

    assign out_valid_next = load_c ? a_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_c && a_valid)
        begin
            luma_addr_reg   <= luma_addr_next;
            chroma_addr_reg <= chroma_addr_next;
            y0_reg          <= a_y0;
            y1_reg          <= a_y1;
            // zero the chroma bytes on luma-only pairs
            u_reg           <= a_flags.chroma_on ? a_u : '0;
            v_reg           <= a_flags.chroma_on ? a_v : '0;
            flags_reg       <= a_flags;
        end
    end

    assign out_valid       = out_valid_reg;
    assign luma_address    = luma_addr_reg;
    assign luma_out_first  = y0_reg;
    assign luma_out_second = y1_reg;
    assign chroma_write    = flags_reg.chroma_on;
    assign chroma_address  = chroma_addr_reg;
    assign blue_out        = u_reg;
    assign red_out         = v_reg;
    assign frame_end       = flags_reg.frame_end;

endmodule

// ===== rtl/yuy2_to_planar_yuv.sv =====
// Top level of the YUY2 to planar YUV address generator.
// Depends on y2p_pkg, y2p_cfg, y2p_scan and y2p_addr.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one packed YUY2 pixel pair
//   (Y0 U Y1 V) per transfer in raster order. Output channel
//   (out_valid/out_ready) carries one result per pair: the Y-plane address
//   of both luma bytes, and in chroma cycles the U/V plane address and bytes.
//   frame_end marks the last pair of the frame.
//   Configuration is over the APB port (mode, input and output sizes);
//   write it only while no pair is in flight.
// The input register, then one pass of address logic into the output
//   register, lie between an input transfer and out_valid rising.
// Throughput: one pair per clock while out_ready holds high; a transfer may
//   take place on both channels in the same cycle.
// Reset clears the row and column counters and empties the pipeline;
//   registers return to 4:2:2 mode at 352x288 in and out.
// When the receiver stalls, the result holds on the outputs, an empty input
//   register takes one more pair, then in_ready drops until out_ready returns.
module yuy2_to_planar_yuv
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [y2p_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [y2p_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [y2p_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [y2p_pkg::BYTE_W-1:0]         luma_first,
    input  logic [y2p_pkg::BYTE_W-1:0]         chroma_blue,
    input  logic [y2p_pkg::BYTE_W-1:0]         luma_second,
    input  logic [y2p_pkg::BYTE_W-1:0]         chroma_red,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [y2p_pkg::LUMA_ADDR_W-1:0]    luma_address,
    output logic [y2p_pkg::BYTE_W-1:0]         luma_out_first,
    output logic [y2p_pkg::BYTE_W-1:0]         luma_out_second,
    output logic                               chroma_write,
    output logic [y2p_pkg::CHROMA_ADDR_W-1:0]  chroma_address,
    output logic [y2p_pkg::BYTE_W-1:0]         blue_out,
    output logic [y2p_pkg::BYTE_W-1:0]         red_out,
    output logic                               frame_end
);

    y2p_pkg::cfg_t                 cfg;
    logic                          a_valid;
    logic                          a_ready;
    logic [$clog2(MAX_HEIGHT)-1:0] a_row;
    logic [$clog2(MAX_WIDTH)-1:0]  a_col;
    logic [y2p_pkg::BYTE_W-1:0]    a_y0, a_u, a_y1, a_v;
    y2p_pkg::pair_flags_t          a_flags;

    y2p_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    y2p_scan
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_scan
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .luma_first  (luma_first),
        .chroma_blue (chroma_blue),
        .luma_second (luma_second),
        .chroma_red  (chroma_red),
        .a_ready     (a_ready),
        .a_valid     (a_valid),
        .a_row       (a_row),
        .a_col       (a_col),
        .a_y0        (a_y0),
        .a_u         (a_u),
        .a_y1        (a_y1),
        .a_v         (a_v),
        .a_flags     (a_flags)
    );

    y2p_addr
    #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    )
    u_addr
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .a_valid         (a_valid),
        .a_ready         (a_ready),
        .a_row           (a_row),
        .a_col           (a_col),
        .a_y0            (a_y0),
        .a_u             (a_u),
        .a_y1            (a_y1),
        .a_v             (a_v),
        .a_flags         (a_flags),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .luma_address    (luma_address),
        .luma_out_first  (luma_out_first),
        .luma_out_second (luma_out_second),
        .chroma_write    (chroma_write),
        .chroma_address  (chroma_address),
        .blue_out        (blue_out),
        .red_out         (red_out),
        .frame_end       (frame_end)
    );

endmodule
